// ===== rtl/force_torque_filter_breaker_unit_defines.svh =====
// Assertion macros used by the checker of this block.
`ifndef FORCE_TORQUE_FILTER_BREAKER_UNIT_DEFINES_SVH
`define FORCE_TORQUE_FILTER_BREAKER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define FTFB_CHECK(name, rst, prop) \
   name: assert property (@(posedge clock) disable iff (rst) prop) \
      else $error("ftfb check failed");

// Check a property on every clock edge, reset included.
`define FTFB_CHECK_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("ftfb check failed");

`endif

// ===== rtl/ftfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ftfb_pkg;

   localparam int AXES      = 6;
   localparam int SUM_W     = 40;
   localparam int VAL_W     = 32;
   localparam int CNT_W     = 7;
   localparam int DIV_W     = 8;
   localparam int TRIP_W    = 14;
   localparam int REQ_W     = 200;
   localparam int RSP_W     = 192;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   typedef enum logic [2:0] {
      REG_WINDOW_LENGTH = 3'd0,
      REG_FILTER_MODE   = 3'd1,
      REG_FORCE_LIMIT   = 3'd2,
      REG_TORQUE_LIMIT  = 3'd3,
      REG_FORCE_EN      = 3'd4,
      REG_TORQUE_EN     = 3'd5,
      REG_TRIP_COUNT    = 3'd6,
      REG_LINK_VALID    = 3'd7
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_STEP,
      ST_FILT_INIT,
      ST_SWEEP,
      ST_SWEEP_END,
      ST_MDIV_START,
      ST_MDIV_WAIT,
      ST_SEL_DECIDE,
      ST_SEL_STORE,
      ST_AXIS_NEXT,
      ST_MUL,
      ST_MACC,
      ST_TRIP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [7:0]        window_length;
      logic              filter_mode;
      logic [31:0]       force_limit;
      logic [31:0]       torque_limit;
      logic              force_en;
      logic              torque_en;
      logic [TRIP_W-1:0] trip_count;
      logic              link_valid;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       accum;
      logic       div_start;
      logic       div_mean;
      logic       ram_wr;
      logic       step;
      logic       filt_init;
      logic       sweep_rd;
      logic       store_mean;
      logic       sel_decide;
      logic       store_median;
      logic       mul;
      logic       macc;
      logic       trip;
      logic       out_load;
      logic [2:0] axis;
      logic [4:0] bit_idx;
      logic [2:0] mstep;
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic cnt_zero;
      logic div_done;
      logic full_next;
      logic median_mode;
      logic link_valid;
      logic sweep_last;
      logic out_free;
   } status_type;

   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(signed'(33'sh0_7FFF_FFFF));
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[VAL_W-1:0];
      end
   endfunction

   function automatic logic [VAL_W-1:0] abs32(input logic signed [VAL_W-1:0] v);
      abs32 = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ftfb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ftfb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ftfb_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ftfb_div
   import ftfb_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [SUM_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]        divisor,
   output      logic                    done,
   output      logic signed [SUM_W-1:0] quotient
);

   localparam int CW = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] quo_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic             neg_ff;
   logic [DIV_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // one quotient bit a cycle, magnitude only
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_ff <= '0;
         dvs_ff <= divisor;
         cnt_ff <= CW'(SUM_W);
         neg_ff <= dividend[SUM_W-1];
      end else if (busy_ff) begin
         rem_ff <= fits ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
         quo_ff <= {quo_ff[SUM_W-2:0], fits};
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -signed'(quo_ff) : signed'(quo_ff);

endmodule
`default_nettype wire

// ===== rtl/ftfb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ftfb_ctrl
   import ftfb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire status_type status,
   output      cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [2:0] axis_ff, axis_in;
   logic [4:0] bit_ff, bit_in;
   logic [2:0] mstep_ff, mstep_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= '0;
         bit_ff   <= '0;
         mstep_ff <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         bit_ff   <= bit_in;
         mstep_ff <= mstep_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      bit_in   = bit_ff;
      mstep_in = mstep_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            axis_in = '0;
            if (status.is_clear || status.cnt_zero) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               if (axis_ff == 3'(AXES - 1)) begin
                  state_in = ST_STEP;
               end else begin
                  axis_in  = axis_ff + 3'd1;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_STEP: begin
            axis_in  = '0;
            state_in = status.full_next ? ST_FILT_INIT : ST_OUT;
         end
         ST_FILT_INIT: begin
            bit_in   = 5'd31;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = ST_SWEEP_END;
            end
         end
         ST_SWEEP_END: begin
            state_in = status.median_mode ? ST_SEL_DECIDE : ST_MDIV_START;
         end
         ST_MDIV_START: state_in = ST_MDIV_WAIT;
         ST_MDIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_AXIS_NEXT;
            end
         end
         ST_SEL_DECIDE: begin
            if (bit_ff == 5'd0) begin
               state_in = ST_SEL_STORE;
            end else begin
               bit_in   = bit_ff - 5'd1;
               state_in = ST_SWEEP;
            end
         end
         ST_SEL_STORE: state_in = ST_AXIS_NEXT;
         ST_AXIS_NEXT: begin
            mstep_in = '0;
            if (axis_ff == 3'(AXES - 1)) begin
               state_in = status.link_valid ? ST_MUL : ST_OUT;
            end else begin
               axis_in  = axis_ff + 3'd1;
               state_in = ST_FILT_INIT;
            end
         end
         ST_MUL: state_in = ST_MACC;
         ST_MACC: begin
            if (mstep_ff == 3'd7) begin
               state_in = ST_TRIP;
            end else begin
               mstep_in = mstep_ff + 3'd1;
               state_in = ST_MUL;
            end
         end
         ST_TRIP: state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.axis    = axis_ff;
      cmd.bit_idx = bit_ff;
      cmd.mstep   = mstep_ff;
      req_tready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_ACCUM: begin
            cmd.clear = status.is_clear;
            cmd.accum = !status.is_clear;
         end
         ST_DIV_START: cmd.div_start = 1'b1;
         ST_DIV_WAIT:  cmd.ram_wr    = status.div_done;
         ST_STEP:      cmd.step      = 1'b1;
         ST_FILT_INIT: cmd.filt_init = 1'b1;
         ST_SWEEP:     cmd.sweep_rd  = 1'b1;
         ST_SWEEP_END: cmd           = cmd;
         ST_MDIV_START: begin
            cmd.div_start = 1'b1;
            cmd.div_mean  = 1'b1;
         end
         ST_MDIV_WAIT: cmd.store_mean   = status.div_done;
         ST_SEL_DECIDE: cmd.sel_decide  = 1'b1;
         ST_SEL_STORE: cmd.store_median = 1'b1;
         ST_AXIS_NEXT: cmd              = cmd;
         ST_MUL:       cmd.mul          = 1'b1;
         ST_MACC:      cmd.macc         = 1'b1;
         ST_TRIP:      cmd.trip         = 1'b1;
         ST_OUT:       cmd.out_load     = status.out_free;
         default:      cmd              = cmd;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/ftfb_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ftfb_dp
   import ftfb_pkg::*;
#(
   parameter int WINDOW_MAX = 128
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire cmd_type          cmd,
   output      status_type       status,
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic             req_tuser,
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      logic [RSP_W-1:0] rsp_tdata,
   output      logic [1:0]       rsp_tuser
);

   localparam int LW    = $clog2(WINDOW_MAX + 1);
   localparam int SW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int DEPTH = AXES * WINDOW_MAX;
   localparam int AW    = $clog2(DEPTH);

   // latched input word
   logic                    is_clear_ff;
   logic signed [VAL_W-1:0] in_ff [AXES];
   logic [CNT_W-1:0]        cnt_ff;

   logic signed [SUM_W-1:0] sum_ff [AXES];
   logic signed [VAL_W-1:0] filt_ff [AXES];
   logic [SW-1:0]           head_ff;
   logic [LW-1:0]           fill_ff;
   logic                    full_ff;
   logic [TRIP_W-1:0]       run_ff;
   logic                    broken_ff;

   logic [LW-1:0]           k_ff;
   logic                    rd_pend_ff;
   logic signed [SUM_W-1:0] acc_ff;
   logic [LW-1:0]           cnt0_ff;
   logic [LW-1:0]           rank_ff;
   logic [VAL_W-1:0]        prefix_ff;

   logic [63:0]             prod_ff;
   logic [63:0]             fsq_ff;
   logic [63:0]             tsq_ff;
   logic [63:0]             flsq_ff;
   logic [63:0]             tlsq_ff;

   logic                    rsp_valid_ff;
   logic [RSP_W-1:0]        rsp_data_ff;
   logic [1:0]              rsp_user_ff;

   logic [LW-1:0]           len;
   logic [LW-1:0]           fill_in;
   logic [SW-1:0]           head_in;
   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;
   logic [VAL_W-1:0]        rd_data;
   logic                    div_done;
   logic signed [SUM_W-1:0] quotient;
   logic signed [SUM_W-1:0] div_dividend;
   logic [DIV_W-1:0]        div_divisor;
   logic [VAL_W-1:0]        sel_mask;
   logic [VAL_W-1:0]        rd_key;
   logic [VAL_W-1:0]        mul_op;
   logic                    trig;
   logic [TRIP_W-1:0]       need;
   logic [TRIP_W-1:0]       run_in;
   logic                    out_ok;
   int                      slot;

   // effective window length
   always_comb begin
      if (cfg.window_length == 8'd0) begin
         len = LW'(1);
      end else if (int'(cfg.window_length) > WINDOW_MAX) begin
         len = LW'(WINDOW_MAX);
      end else begin
         len = LW'(cfg.window_length);
      end
   end

   assign fill_in = (int'(fill_ff) + 1 >= int'(len)) ? len : fill_ff + LW'(1);
   assign head_in = (int'(head_ff) == WINDOW_MAX - 1) ? '0 : SW'(int'(head_ff) + 1);

   // newest entry first, walking back around the ring
   always_comb begin
      slot = int'(head_ff) - 1 - int'(k_ff);
      if (slot < 0) begin
         slot = slot + WINDOW_MAX;
      end
   end

   assign wr_addr = AW'(int'(cmd.axis) * WINDOW_MAX + int'(head_ff));
   assign rd_addr = AW'(int'(cmd.axis) * WINDOW_MAX + slot);

   ftfb_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.ram_wr),
      .wr_addr (wr_addr),
      .wr_data (sat32(quotient)),
      .rd_en   (cmd.sweep_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign div_dividend = cmd.div_mean ? acc_ff : sum_ff[cmd.axis];
   assign div_divisor  = cmd.div_mean ? DIV_W'(len) : DIV_W'(cnt_ff);

   ftfb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // bits above the one being decided; flip sign bit to order as unsigned
   assign sel_mask = VAL_W'({VAL_W{1'b1}} << (6'(cmd.bit_idx) + 6'd1));
   assign rd_key   = rd_data ^ 32'h8000_0000;

   always_comb begin
      case (cmd.mstep) inside
         [3'd0:3'd5]: mul_op = abs32(filt_ff[cmd.mstep]);
         3'd6:        mul_op = cfg.force_limit;
         default:     mul_op = cfg.torque_limit;
      endcase
   end

   assign trig   = (cfg.force_en && fsq_ff >= flsq_ff) || (cfg.torque_en && tsq_ff >= tlsq_ff);
   assign need   = (cfg.trip_count == '0) ? TRIP_W'(1) : cfg.trip_count;
   assign run_in = trig ? run_ff + TRIP_W'(1) : '0;
   assign out_ok = full_ff && cfg.link_valid;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_clear_ff <= req_tuser;
         for (int a = 0; a < AXES; a++) begin
            in_ff[a] <= req_tdata[a*VAL_W +: VAL_W];
         end
         cnt_ff <= req_tdata[AXES*VAL_W +: CNT_W];
      end
   end

   // step state and filter results
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int a = 0; a < AXES; a++) begin
            sum_ff[a]  <= '0;
            filt_ff[a] <= '0;
         end
         head_ff   <= '0;
         fill_ff   <= '0;
         full_ff   <= 1'b0;
         run_ff    <= '0;
         broken_ff <= 1'b0;
      end else begin
         if (cmd.accum) begin
            for (int a = 0; a < AXES; a++) begin
               logic signed [SUM_W:0] s;
               s = {sum_ff[a][SUM_W-1], sum_ff[a]} + (SUM_W+1)'(in_ff[a]);
               if (s[SUM_W] != s[SUM_W-1]) begin
                  sum_ff[a] <= s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
               end else begin
                  sum_ff[a] <= s[SUM_W-1:0];
               end
            end
         end
         if (cmd.step) begin
            for (int a = 0; a < AXES; a++) begin
               sum_ff[a] <= '0;
            end
            head_ff <= head_in;
            fill_ff <= fill_in;
            full_ff <= (fill_in >= len);
         end
         if (cmd.store_mean) begin
            filt_ff[cmd.axis] <= sat32(quotient);
         end
         if (cmd.store_median) begin
            filt_ff[cmd.axis] <= prefix_ff ^ 32'h8000_0000;
         end
         if (cmd.trip) begin
            if (run_in >= need) begin
               broken_ff <= 1'b1;
               run_ff    <= '0;
            end else begin
               run_ff <= run_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.sweep_rd;
      end
   end

   // window sweep: sum for the mean, count below-bit-zero keys for the median
   always_ff @(posedge clock) begin
      if (cmd.filt_init) begin
         k_ff      <= '0;
         acc_ff    <= '0;
         cnt0_ff   <= '0;
         prefix_ff <= '0;
         rank_ff   <= len >> 1;
      end else if (cmd.sel_decide) begin
         k_ff    <= '0;
         cnt0_ff <= '0;
         if (rank_ff >= cnt0_ff) begin
            prefix_ff[cmd.bit_idx] <= 1'b1;
            rank_ff                <= rank_ff - cnt0_ff;
         end
      end else begin
         if (cmd.sweep_rd) begin
            k_ff <= k_ff + LW'(1);
         end
         if (rd_pend_ff) begin
            acc_ff <= acc_ff + SUM_W'(signed'(rd_data));
            if (((rd_key & sel_mask) == (prefix_ff & sel_mask)) && !rd_key[cmd.bit_idx]) begin
               cnt0_ff <= cnt0_ff + LW'(1);
            end
         end
      end
   end

   // squared magnitudes: each product is registered, then accumulated before the next is formed
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= 64'(mul_op) * 64'(mul_op);
      end
      if (cmd.macc) begin
         case (cmd.mstep) inside
            3'd0:        fsq_ff  <= prod_ff;
            [3'd1:3'd2]: fsq_ff  <= fsq_ff + prod_ff;
            3'd3:        tsq_ff  <= prod_ff;
            [3'd4:3'd5]: tsq_ff  <= tsq_ff + prod_ff;
            3'd6:        flsq_ff <= prod_ff;
            default:     tlsq_ff <= prod_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         for (int a = 0; a < AXES; a++) begin
            rsp_data_ff[a*VAL_W +: VAL_W] <= out_ok ? filt_ff[a] : '0;
         end
         rsp_user_ff <= {broken_ff, out_ok};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign status.is_clear    = is_clear_ff;
   assign status.cnt_zero    = (cnt_ff == '0);
   assign status.div_done    = div_done;
   assign status.full_next   = (fill_in >= len);
   assign status.median_mode = cfg.filter_mode;
   assign status.link_valid  = cfg.link_valid;
   assign status.sweep_last  = (k_ff == len - LW'(1));
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

endmodule
`default_nettype wire

// ===== rtl/force_torque_filter_breaker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   ports   tdata / tuser                                       per word
// req       req_    six Q16.16 axes, sample_count / cmd                 one step input
// rsp       rsp_    six filtered Q16.16 axes / filtered_valid, broken   one result
// csr       csr_    eight registers at 4*index                          one write
//
// Clear or plain accumulate: load, accumulate or clear, output. Step close:
// 6 serial divides through the shared divider. Full window, mean: per axis
// a sweep of the window RAM read port, a divide and one axis step; median:
// per axis 32 radix passes over the window. Trip check: 8 products on one
// 32x32 multiplier plus one compare. Reset is synchronous; the window RAM
// is not cleared, as only entries written since the last clear are read.
// A new word is taken while the previous result waits in the output
// register; a stalled result holds the block in its final state.
module force_torque_filter_breaker_unit
   import ftfb_pkg::*;
#(
   parameter int WINDOW_MAX = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   // force_x, force_y, force_z, torque_x, torque_y, torque_z, sample_count, pad
   input  wire logic [REQ_W-1:0]  req_tdata,
   // cmd
   input  wire logic              req_tuser,
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   // filt_force_x, filt_force_y, filt_force_z, filt_torque_x, filt_torque_y,
   // filt_torque_z
   output      logic [RSP_W-1:0]  rsp_tdata,
   // filtered_valid, broken
   output      logic [1:0]        rsp_tuser,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output      logic [CSR_DW-1:0] csr_prdata,
   output      logic              csr_pready
);

   cfg_type       cfg_ff;
   cmd_type       cmd;
   status_type    status;
   reg_index_type reg_idx;
   logic          csr_wr;

   assign reg_idx    = reg_index_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length <= 8'd1;
         cfg_ff.filter_mode   <= 1'b0;
         cfg_ff.force_limit   <= 32'd6553600;
         cfg_ff.torque_limit  <= 32'd655360;
         cfg_ff.force_en      <= 1'b0;
         cfg_ff.torque_en     <= 1'b0;
         cfg_ff.trip_count    <= TRIP_W'(10);
         cfg_ff.link_valid    <= 1'b0;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_WINDOW_LENGTH: cfg_ff.window_length <= csr_pwdata[7:0];
            REG_FILTER_MODE:   cfg_ff.filter_mode   <= csr_pwdata[0];
            REG_FORCE_LIMIT:   cfg_ff.force_limit   <= csr_pwdata;
            REG_TORQUE_LIMIT:  cfg_ff.torque_limit  <= csr_pwdata;
            REG_FORCE_EN:      cfg_ff.force_en      <= csr_pwdata[0];
            REG_TORQUE_EN:     cfg_ff.torque_en     <= csr_pwdata[0];
            REG_TRIP_COUNT:    cfg_ff.trip_count    <= csr_pwdata[TRIP_W-1:0];
            REG_LINK_VALID:    cfg_ff.link_valid    <= csr_pwdata[0];
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WINDOW_LENGTH: csr_prdata = CSR_DW'(cfg_ff.window_length);
         REG_FILTER_MODE:   csr_prdata = CSR_DW'(cfg_ff.filter_mode);
         REG_FORCE_LIMIT:   csr_prdata = cfg_ff.force_limit;
         REG_TORQUE_LIMIT:  csr_prdata = cfg_ff.torque_limit;
         REG_FORCE_EN:      csr_prdata = CSR_DW'(cfg_ff.force_en);
         REG_TORQUE_EN:     csr_prdata = CSR_DW'(cfg_ff.torque_en);
         REG_TRIP_COUNT:    csr_prdata = CSR_DW'(cfg_ff.trip_count);
         REG_LINK_VALID:    csr_prdata = CSR_DW'(cfg_ff.link_valid);
         default:           csr_prdata = '0;
      endcase
   end

   ftfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ftfb_dp #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== rtl/ftfb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "force_torque_filter_breaker_unit_defines.svh"
module ftfb_checker
   import ftfb_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic [1:0]       rsp_tuser
);

   `FTFB_CHECK(a_rsp_hold, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `FTFB_CHECK(a_invalid_zero, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
   `FTFB_CHECK(a_one_word, reset, req_tvalid && req_tready |=> !req_tready)
   `FTFB_CHECK_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid)

endmodule

bind force_torque_filter_breaker_unit ftfb_checker u_ftfb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import ftfb_pkg::*;

   localparam int WMAX = 128;
   localparam longint SUM_HI = 64'sd549755813887;
   localparam longint SUM_LO = -64'sd549755813888;

   typedef struct packed {
      logic              broken;
      logic              fvalid;
      logic [5:0][31:0]  axis;
   } result_type;

   typedef struct {
      bit       cmd;
      int       axis [6];
      int       cnt;
      bit       typed_zero;
   } row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   force_torque_filter_breaker_unit uut (.*);

   always #10 clock = ~clock;

   // shadow of the block's registers and state
   int          win_len_reg = 1;
   bit          median_mode = 0;
   logic [31:0] force_lim = 32'd6553600;
   logic [31:0] torque_lim = 32'd655360;
   bit          force_chk = 0;
   bit          torque_chk = 0;
   int          trip_reg = 10;
   bit          linked = 0;

   longint      step_sum [6];
   int          avg_ring [6][WMAX];
   int          ring_fill;
   int          ring_head;
   int          filt_val [6];
   bit          ring_full;
   int          over_run;
   bit          tripped;

   result_type  words_due [$];
   int          errors = 0;
   bit          calm = 0;
   bit          hold_req = 0;

   function automatic int clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   function automatic longint unsigned mag_sq(int a, int b, int c);
      longint unsigned s;
      longint x [3];
      s = 0;
      x[0] = a; x[1] = b; x[2] = c;
      for (int i = 0; i < 3; i++) begin
         if (x[i] < 0) x[i] = -x[i];
         s += longint'(x[i]) * longint'(x[i]);
      end
      return s;
   endfunction

   function automatic void clear_state();
      for (int a = 0; a < 6; a++) begin
         step_sum[a] = 0;
         filt_val[a] = 0;
      end
      ring_fill = 0;
      ring_head = 0;
      ring_full = 0;
      over_run = 0;
      tripped = 0;
   endfunction

   function automatic void refilter(int len);
      int buff [WMAX];
      longint acc;
      int t, j;
      for (int a = 0; a < 6; a++) begin
         acc = 0;
         for (int k = 0; k < len; k++) begin
            buff[k] = avg_ring[a][(ring_head + WMAX - 1 - k) % WMAX];
            acc += buff[k];
         end
         if (!median_mode) begin
            filt_val[a] = clip32(acc / len);
         end else begin
            for (int i = 1; i < len; i++) begin
               t = buff[i];
               j = i;
               while (j > 0 && buff[j-1] > t) begin
                  buff[j] = buff[j-1];
                  j--;
               end
               buff[j] = t;
            end
            filt_val[a] = buff[len/2];
         end
      end
   endfunction

   function automatic void check_overload();
      bit hit;
      int need;
      hit = 0;
      need = (trip_reg == 0) ? 1 : trip_reg;
      if (force_chk && mag_sq(filt_val[0], filt_val[1], filt_val[2]) >=
          longint'(force_lim) * longint'(force_lim))
         hit = 1;
      if (torque_chk && mag_sq(filt_val[3], filt_val[4], filt_val[5]) >=
          longint'(torque_lim) * longint'(torque_lim))
         hit = 1;
      over_run = hit ? ((over_run + 1) & 16'h3FFF) : 0;
      if (over_run >= need) begin
         tripped = 1;
         over_run = 0;
      end
   endfunction

   function automatic result_type step_filter(bit cmd, int axis [6], int cnt);
      result_type r;
      longint s;
      int len;
      bit ok;
      if (cmd) begin
         clear_state();
      end else begin
         for (int a = 0; a < 6; a++) begin
            s = step_sum[a] + longint'(axis[a]);
            if (s > SUM_HI) s = SUM_HI;
            if (s < SUM_LO) s = SUM_LO;
            step_sum[a] = s;
         end
         if (cnt != 0) begin
            len = (win_len_reg == 0) ? 1 : (win_len_reg > WMAX ? WMAX : win_len_reg);
            for (int a = 0; a < 6; a++) begin
               avg_ring[a][ring_head] = clip32(step_sum[a] / cnt);
               step_sum[a] = 0;
            end
            ring_head = (ring_head + 1) % WMAX;
            ring_fill++;
            if (ring_fill > len) ring_fill = len;
            ring_full = (ring_fill >= len);
            if (ring_full) begin
               refilter(len);
               if (linked) check_overload();
            end
         end
      end
      ok = ring_full && linked;
      for (int a = 0; a < 6; a++) r.axis[a] = ok ? filt_val[a] : 32'd0;
      r.fvalid = ok;
      r.broken = tripped;
      return r;
   endfunction

   function automatic int rand_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic int rand_axis();
      int r;
      r = $urandom_range(99);
      if (r < 30) return $urandom;
      if (r < 70) return int'($urandom_range(32'h60000)) - 32'h30000;
      if (r < 85) begin
         case ($urandom_range(3))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 0;
            default: return -1;
         endcase
      end
      return int'($urandom_range(32'h2000000)) - 32'h1000000;
   endfunction

   task automatic send_word(bit cmd, int axis [6], int cnt, bit typed_zero);
      logic [REQ_W-1:0] d;
      result_type r;
      int gap;
      d = '0;
      for (int a = 0; a < 6; a++) d[a*32 +: 32] = axis[a];
      d[192 +: 7] = cnt[6:0];
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      r = step_filter(cmd, axis, cnt);
      words_due.insert(words_due.size(), typed_zero ? result_type'('0) : r);
      gap = rand_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(idx) << 2;
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
   endtask

   task automatic set_regs(int wl, bit fm, logic [31:0] fl, logic [31:0] tl,
                           bit fe, bit te, int tc, bit lv);
      drain();
      csr_write(REG_WINDOW_LENGTH, 32'(wl));
      csr_write(REG_FILTER_MODE, 32'(fm));
      csr_write(REG_FORCE_LIMIT, fl);
      csr_write(REG_TORQUE_LIMIT, tl);
      csr_write(REG_FORCE_EN, 32'(fe));
      csr_write(REG_TORQUE_EN, 32'(te));
      csr_write(REG_TRIP_COUNT, 32'(tc));
      csr_write(REG_LINK_VALID, 32'(lv));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      win_len_reg = wl & 8'hFF;
      median_mode = fm;
      force_lim   = fl;
      torque_lim  = tl;
      force_chk   = fe;
      torque_chk  = te;
      trip_reg    = tc & 16'h3FFF;
      linked      = lv;
   endtask

   task automatic random_words(int n, int close_pct);
      int axis [6];
      int cnt;
      bit cmd;
      for (int i = 0; i < n; i++) begin
         for (int a = 0; a < 6; a++) axis[a] = rand_axis();
         cmd = ($urandom_range(99) < 3);
         cnt = 0;
         if ($urandom_range(99) < close_pct)
            cnt = ($urandom_range(19) == 0) ? $urandom_range(127, 65) : $urandom_range(64, 1);
         send_word(cmd, axis, cnt, 1'b0);
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 0;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            n = rand_gap();
            if (n == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               repeat (n - 1) @(posedge clock);
            end
         end
      end
   end

   task automatic flag_diff(string what, longint unsigned w, longint unsigned g);
      errors++;
      if (errors <= 10)
         $display("mismatch %s: expected %h, got %h", what, w, g);
   endtask

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[1], rsp_tuser[0], rsp_tdata};
         if (words_due.size() == 0) begin
            flag_diff("unexpected word", 0, got.axis[0]);
         end else begin
            want = words_due.pop_front();
            for (int a = 0; a < 6; a++)
               if (got.axis[a] !== want.axis[a]) flag_diff("axis", want.axis[a], got.axis[a]);
            if (got.fvalid !== want.fvalid) flag_diff("filtered_valid", want.fvalid, got.fvalid);
            if (got.broken !== want.broken) flag_diff("broken", want.broken, got.broken);
         end
      end
   end

   initial begin
      #(64'd400_000_000);
      $display("** force_torque_filter_breaker_unit: FAILED **");
      $finish;
   end

   initial begin
      row_type rows [$];
      row_type rw;
      int axis [6];
      clear_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // after reset the link is down, so results read as zero
      rw.cmd = 0; rw.cnt = 1; rw.typed_zero = 1;
      foreach (rw.axis[a]) rw.axis[a] = 32'h7FFFFFFF;
      rows.insert(rows.size(), rw);
      foreach (rw.axis[a]) rw.axis[a] = 32'h80000000;
      rw.cnt = 0;
      rows.insert(rows.size(), rw);
      rw.cmd = 1; rw.cnt = 5;
      foreach (rw.axis[a]) rw.axis[a] = 32'h12345678;
      rows.insert(rows.size(), rw);
      foreach (rows[i]) send_word(rows[i].cmd, rows[i].axis, rows[i].cnt, rows[i].typed_zero);
      rows.delete();

      // torque limit of zero is an overload on every closed step
      set_regs(1, 0, 32'h00050000, 32'd0, 1, 1, 2, 1);
      rw.typed_zero = 0;
      rw.cmd = 0;
      for (int k = 0; k < 2; k++) begin
         foreach (rw.axis[a]) rw.axis[a] = k ? 32'h80000000 : 32'h7FFFFFFF;
         rw.cnt = 0; rows.insert(rows.size(), rw);
         rw.cnt = 1; rows.insert(rows.size(), rw);
      end
      foreach (rw.axis[a]) rw.axis[a] = 32'h7FFFFFFF;
      rw.cnt = 64;  rows.insert(rows.size(), rw);
      rw.cnt = 127; rows.insert(rows.size(), rw);
      foreach (rw.axis[a]) rw.axis[a] = (a % 2) ? -32'sd65536 : 32'sd196608;
      rw.cnt = 1;   rows.insert(rows.size(), rw);
      rw.cnt = 3;   rows.insert(rows.size(), rw);
      foreach (rw.axis[a]) rw.axis[a] = 0;
      rw.cnt = 2;   rows.insert(rows.size(), rw);
      rw.cmd = 1; rw.typed_zero = 1; rows.insert(rows.size(), rw);
      rw.cmd = 0; rw.typed_zero = 0;
      foreach (rw.axis[a]) rw.axis[a] = 32'h00010000;
      rw.cnt = 1;   rows.insert(rows.size(), rw);
      foreach (rows[i]) send_word(rows[i].cmd, rows[i].axis, rows[i].cnt, rows[i].typed_zero);

      // short mean window, with a long hold on the result side
      set_regs(4, 0, 32'h00020000, 32'h00030000, 1, 1, 3, 1);
      random_words(20, 50);
      hold_req = 1;
      random_words(40, 50);

      // short median window; pause once until everything is back
      set_regs(5, 1, 32'h00040000, 32'h00010000, 1, 0, 1, 1);
      random_words(20, 60);
      drain();
      calm = 1;
      random_words(20, 60);
      calm = 0;

      // largest window: fill with mean, then a few median steps, then mean above the maximum length
      set_regs(128, 0, 32'h00008000, 32'hFFFFFFFF, 1, 1, 10000, 1);
      random_words(140, 100);
      set_regs(128, 1, 32'h00008000, 32'h00008000, 1, 1, 2, 1);
      random_words(5, 100);
      set_regs(255, 0, 32'hFFFFFFFF, 32'h00008000, 0, 1, 16383, 1);
      random_words(5, 100);

      // lowered window, zero length and zero trip count, link down then up
      set_regs(3, 1, 32'd0, 32'd0, 1, 1, 0, 0);
      random_words(15, 50);
      set_regs(0, 0, 32'h00010000, 32'h00010000, 0, 1, 0, 1);
      random_words(15, 50);

      // run the 40-bit sums into saturation, then close the step
      set_regs(2, 0, 32'h00010000, 32'h00010000, 1, 1, 10, 1);
      calm = 1;
      for (int i = 0; i < 258; i++) begin
         foreach (axis[a]) axis[a] = (a < 3) ? 32'h7FFFFFFF : 32'h80000000;
         send_word(1'b0, axis, (i == 257) ? 1 : 0, 1'b0);
      end
      calm = 0;
      random_words(10, 40);

      drain();
      repeat (30) @(posedge clock);
      if (errors == 0 && words_due.size() == 0) begin
         $display("** force_torque_filter_breaker_unit: PASSED **");
      end else begin
         $display("** force_torque_filter_breaker_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ftfb_pkg.sv
rtl/ftfb_ram.sv
rtl/ftfb_div.sv
rtl/ftfb_ctrl.sv
rtl/ftfb_dp.sv
rtl/force_torque_filter_breaker_unit.sv
rtl/ftfb_checker.sv
tb/testbench.sv
